FILE: hdl/abrg_pkg.sv
// ----------------------------------------------------------------------------
// abrg_pkg: shared types and constants for the audio block ring
// Operation and result codes, transaction structs and header row layout.
// ----------------------------------------------------------------------------
package abrg_pkg;

    localparam int MAX_SLOTS_DEF    = 16;
    localparam int BLOCK_FRAMES_DEF = 64;
    localparam int MAX_PLANES_DEF   = 8;

    localparam logic [2:0] OP_PUSH_HDR  = 3'd0;
    localparam logic [2:0] OP_PUSH_DATA = 3'd1;
    localparam logic [2:0] OP_POP_HDR   = 3'd2;
    localparam logic [2:0] OP_POP_DATA  = 3'd3;
    localparam logic [2:0] OP_STOP      = 3'd4;

    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_DROPPED   = 3'd1;
    localparam logic [2:0] RC_INVALID   = 3'd2;
    localparam logic [2:0] RC_EXHAUSTED = 3'd3;
    localparam logic [2:0] RC_STOPPED   = 3'd4;
    localparam logic [2:0] RC_EMPTY     = 3'd5;

    localparam logic [1:0] CFG_PLANES = 2'd0;
    localparam logic [1:0] CFG_BPPF   = 2'd1;
    localparam logic [1:0] CFG_SLOTS  = 2'd2;

    localparam logic [3:0] PLANES_RST = 4'd1;
    localparam logic [5:0] BPPF_RST   = 6'd4;
    localparam logic [4:0] SLOTS_RST  = 5'd16;
    localparam logic [5:0] FRAME_BYTES_MAX = 6'd32;

    typedef struct packed {
        logic [2:0]  operation;
        logic [6:0]  frame_count;
        logic [63:0] timestamp;
        logic [63:0] data_word;
    } s_item_t;

    typedef struct packed {
        logic [2:0]  result_code;
        logic [2:0]  queue_status;
        logic        block_found;
        logic [63:0] block_sequence;
        logic [63:0] block_timestamp;
        logic [63:0] gap_first_sequence;
        logic [63:0] gap_timestamp;
        logic [31:0] gap_count;
        logic [6:0]  block_frames;
        logic [11:0] block_bytes;
        logic [63:0] payload_word;
        logic        last_word;
    } m_item_t;

    typedef struct packed {
        logic [63:0] sequence_num;
        logic [63:0] stamp;
        logic [63:0] gap_first;
        logic [63:0] gap_stamp;
        logic [31:0] gap_count;
        logic [6:0]  frames;
        logic [11:0] bytes;
    } hdr_row_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

FILE: hdl/abrg_store.sv
// ----------------------------------------------------------------------------
// abrg_store: slot header memory and payload memory
// Two single-port-write, registered-read memories for headers and words.
// ----------------------------------------------------------------------------
module abrg_store #(
    parameter int SLOTS = abrg_pkg::MAX_SLOTS_DEF,
    parameter int WORDS = abrg_pkg::BLOCK_FRAMES_DEF * 4,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int AW = (SLOTS * WORDS > 1) ? $clog2(SLOTS * WORDS) : 1
) (
    input  logic                aclk,
    input  logic                hdr_rd_en,
    input  logic [SW-1:0]       hdr_rd_addr,
    output abrg_pkg::hdr_row_t  hdr_rd_data,
    input  logic                hdr_wr_en,
    input  logic [SW-1:0]       hdr_wr_addr,
    input  abrg_pkg::hdr_row_t  hdr_wr_data,
    input  logic                pay_rd_en,
    input  logic [AW-1:0]       pay_rd_addr,
    output logic [63:0]         pay_rd_data,
    input  logic                pay_wr_en,
    input  logic [AW-1:0]       pay_wr_addr,
    input  logic [63:0]         pay_wr_data
);

    abrg_pkg::hdr_row_t hdr_mem [SLOTS];
    logic [63:0]        pay_mem [SLOTS * WORDS];

    always_ff @(posedge aclk) begin
        if (hdr_wr_en) begin
            hdr_mem[hdr_wr_addr] <= hdr_wr_data;
        end
        if (hdr_rd_en) begin
            hdr_rd_data <= hdr_mem[hdr_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_wr_en) begin
            pay_mem[pay_wr_addr] <= pay_wr_data;
        end
        if (pay_rd_en) begin
            pay_rd_data <= pay_mem[pay_rd_addr];
        end
    end

endmodule

FILE: hdl/audio_block_ring_with_gap_tracking.sv
// ----------------------------------------------------------------------------
// audio_block_ring_with_gap_tracking: slot ring of audio blocks with gap log
// Push/pop of block headers and payload words, drop-gap tracking, sticky status.
// ----------------------------------------------------------------------------
// On accept a transaction issues the header or payload memory read; in the
// EXEC state that follows, it updates the ring state, writes memory and loads
// the result register. A new transaction is taken only from the IDLE state,
// after the last one has left EXEC; a result held by m_ready stalls only the
// EXEC state of the following transaction. Memories need no clearing.
module audio_block_ring_with_gap_tracking #(
    parameter int MAX_SLOTS    = abrg_pkg::MAX_SLOTS_DEF,
    parameter int BLOCK_FRAMES = abrg_pkg::BLOCK_FRAMES_DEF,
    parameter int MAX_PLANES   = abrg_pkg::MAX_PLANES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  abrg_pkg::s_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output abrg_pkg::m_item_t  m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [5:0]         cfg_data
);

    localparam int WPS = BLOCK_FRAMES * 4;
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW  = $clog2(MAX_SLOTS + 1);
    localparam int CW  = $clog2(WPS + 1);
    localparam int AW  = (MAX_SLOTS * WPS > 1) ? $clog2(MAX_SLOTS * WPS) : 1;
    localparam logic [8:0]  SLOTS9  = 9'(MAX_SLOTS);
    localparam logic [10:0] FRAMES11 = 11'(BLOCK_FRAMES);
    localparam logic [3:0]  PLANES4 = 4'(MAX_PLANES);
    localparam logic [AW-1:0] WPS_A = AW'(WPS);

    abrg_pkg::state_t  state_reg, state_next;
    abrg_pkg::s_item_t item_reg;
    abrg_pkg::m_item_t m_item_reg, m_item_next;
    logic              m_valid_reg, m_valid_next;

    logic [3:0] plane_count_reg;
    logic [5:0] bppf_reg;
    logic [4:0] slot_count_reg;

    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [FW-1:0] filled_reg, filled_next;
    logic [63:0]   next_seq_reg, next_seq_next;
    logic [63:0]   gap_first_reg, gap_first_next;
    logic [63:0]   gap_time_reg, gap_time_next;
    logic [31:0]   gap_count_reg, gap_count_next;
    logic [2:0]    sticky_reg, sticky_next;
    logic [CW-1:0] fill_pos_reg, fill_pos_next;
    logic [CW-1:0] fill_len_reg, fill_len_next;
    logic [CW-1:0] drain_pos_reg, drain_pos_next;
    logic [CW-1:0] drain_len_reg, drain_len_next;
    logic          filling_reg, filling_next;
    logic          draining_reg, draining_next;

    logic               hdr_rd_en, hdr_wr_en, pay_rd_en, pay_wr_en;
    logic [SW-1:0]      hdr_rd_addr;
    abrg_pkg::hdr_row_t hdr_rd_data, hdr_wr_data;
    logic [AW-1:0]      pay_rd_addr, pay_wr_addr;
    logic [63:0]        pay_rd_data;

    logic       s_fire, exec_go;
    logic [8:0] eff_slots;
    logic [9:0] frame_bytes;
    logic [12:0] block_bytes;
    logic       cfg_bad;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s, input logic [8:0] eff);
        logic [8:0] inc;
        inc = 9'(s) + 9'd1;
        return (inc >= eff) ? '0 : SW'(inc);
    endfunction

    assign s_ready   = (state_reg == abrg_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign exec_go   = (state_reg == abrg_pkg::ST_EXEC) && (!m_valid_reg || m_ready);

    always_comb begin
        if (slot_count_reg == 5'd0) begin
            eff_slots = 9'd1;
        end else if (9'(slot_count_reg) > SLOTS9) begin
            eff_slots = SLOTS9;
        end else begin
            eff_slots = 9'(slot_count_reg);
        end
    end

    assign frame_bytes = 10'(plane_count_reg) * 10'(bppf_reg);
    assign block_bytes = 13'(item_reg.frame_count) * 13'(frame_bytes[5:0]);
    assign cfg_bad = (plane_count_reg == 4'd0) || (plane_count_reg > PLANES4)
        || (bppf_reg == 6'd0) || (frame_bytes > 10'(abrg_pkg::FRAME_BYTES_MAX))
        || (slot_count_reg == 5'd0) || (9'(slot_count_reg) > SLOTS9);

    // read issue on accept
    assign hdr_rd_en   = s_fire && (s_item.operation == abrg_pkg::OP_POP_HDR);
    assign hdr_rd_addr = draining_reg ? next_slot(read_slot_reg, eff_slots) : read_slot_reg;
    assign pay_rd_en   = s_fire && (s_item.operation == abrg_pkg::OP_POP_DATA);
    assign pay_rd_addr = AW'(read_slot_reg) * WPS_A + AW'(drain_pos_reg);

    assign hdr_wr_data = '{sequence_num: next_seq_reg, stamp: item_reg.timestamp,
                           gap_first: gap_first_reg, gap_stamp: gap_time_reg,
                           gap_count: gap_count_reg, frames: item_reg.frame_count,
                           bytes: block_bytes[11:0]};
    assign pay_wr_addr = AW'(write_slot_reg) * WPS_A + AW'(fill_pos_reg);

    always_comb begin
        logic [SW-1:0] rs;
        logic [FW-1:0] fs;
        logic [12:0]   dl;
        logic [2:0]    rc;
        state_next      = state_reg;
        m_item_next     = m_item_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        filled_next     = filled_reg;
        next_seq_next   = next_seq_reg;
        gap_first_next  = gap_first_reg;
        gap_time_next   = gap_time_reg;
        gap_count_next  = gap_count_reg;
        sticky_next     = sticky_reg;
        fill_pos_next   = fill_pos_reg;
        fill_len_next   = fill_len_reg;
        drain_pos_next  = drain_pos_reg;
        drain_len_next  = drain_len_reg;
        filling_next    = filling_reg;
        draining_next   = draining_reg;
        hdr_wr_en       = 1'b0;
        pay_wr_en       = 1'b0;
        rs = read_slot_reg;
        fs = filled_reg;
        dl = '0;
        rc = abrg_pkg::RC_INVALID;

        if (s_fire) begin
            state_next = abrg_pkg::ST_EXEC;
        end

        if (exec_go) begin
            m_item_next = '0;
            unique case (item_reg.operation)
                abrg_pkg::OP_PUSH_HDR: begin
                    if (filling_reg) begin
                        rc = abrg_pkg::RC_INVALID;
                    end else if (sticky_reg != abrg_pkg::RC_OK) begin
                        rc = sticky_reg;
                    end else if (item_reg.frame_count == 7'd0
                                 || 11'(item_reg.frame_count) > FRAMES11 || cfg_bad) begin
                        sticky_next = abrg_pkg::RC_INVALID;
                        rc = abrg_pkg::RC_INVALID;
                    end else if (next_seq_reg == '1) begin
                        sticky_next = abrg_pkg::RC_EXHAUSTED;
                        rc = abrg_pkg::RC_EXHAUSTED;
                    end else begin
                        next_seq_next = next_seq_reg + 64'd1;
                        if (9'(filled_reg) >= 9'(slot_count_reg)) begin
                            if (gap_count_reg == 32'd0) begin
                                gap_first_next = next_seq_reg;
                                gap_time_next  = item_reg.timestamp;
                            end
                            if (gap_count_reg != '1) begin
                                gap_count_next = gap_count_reg + 32'd1;
                            end
                            rc = abrg_pkg::RC_DROPPED;
                        end else begin
                            hdr_wr_en      = 1'b1;
                            gap_first_next = '0;
                            gap_time_next  = '0;
                            gap_count_next = '0;
                            filling_next   = 1'b1;
                            fill_pos_next  = '0;
                            fill_len_next  = CW'((block_bytes + 13'd7) >> 3);
                            rc = abrg_pkg::RC_OK;
                        end
                    end
                end
                abrg_pkg::OP_PUSH_DATA: begin
                    if (filling_reg) begin
                        pay_wr_en = 1'b1;
                        fill_pos_next = fill_pos_reg + CW'(1);
                        if (fill_pos_next >= fill_len_reg) begin
                            filling_next    = 1'b0;
                            fill_pos_next   = '0;
                            write_slot_next = next_slot(write_slot_reg, eff_slots);
                            if (9'(filled_reg) < SLOTS9) begin
                                filled_next = filled_reg + FW'(1);
                            end
                        end
                        rc = abrg_pkg::RC_OK;
                    end
                end
                abrg_pkg::OP_POP_HDR: begin
                    if (draining_reg) begin
                        rs = next_slot(rs, eff_slots);
                        if (fs != '0) fs = fs - FW'(1);
                        draining_next  = 1'b0;
                        drain_pos_next = '0;
                        drain_len_next = '0;
                    end
                    if (fs == '0) begin
                        rc = abrg_pkg::RC_EMPTY;
                    end else begin
                        m_item_next.block_found        = 1'b1;
                        m_item_next.block_sequence     = hdr_rd_data.sequence_num;
                        m_item_next.block_timestamp    = hdr_rd_data.stamp;
                        m_item_next.gap_first_sequence = hdr_rd_data.gap_first;
                        m_item_next.gap_timestamp      = hdr_rd_data.gap_stamp;
                        m_item_next.gap_count          = hdr_rd_data.gap_count;
                        m_item_next.block_frames       = hdr_rd_data.frames;
                        m_item_next.block_bytes        = hdr_rd_data.bytes;
                        dl = (13'(hdr_rd_data.bytes) + 13'd7) >> 3;
                        drain_len_next = CW'(dl);
                        drain_pos_next = '0;
                        draining_next  = 1'b1;
                        if (dl == 13'd0) begin
                            rs = next_slot(rs, eff_slots);
                            fs = fs - FW'(1);
                            draining_next  = 1'b0;
                            drain_len_next = '0;
                        end
                        rc = abrg_pkg::RC_OK;
                    end
                    read_slot_next = rs;
                    filled_next    = fs;
                end
                abrg_pkg::OP_POP_DATA: begin
                    if (!draining_reg) begin
                        rc = abrg_pkg::RC_EMPTY;
                    end else begin
                        m_item_next.payload_word = pay_rd_data;
                        drain_pos_next = drain_pos_reg + CW'(1);
                        if (drain_pos_next >= drain_len_reg) begin
                            m_item_next.last_word = 1'b1;
                            read_slot_next = next_slot(read_slot_reg, eff_slots);
                            if (filled_reg != '0) filled_next = filled_reg - FW'(1);
                            draining_next  = 1'b0;
                            drain_pos_next = '0;
                            drain_len_next = '0;
                        end
                        rc = abrg_pkg::RC_OK;
                    end
                end
                abrg_pkg::OP_STOP: begin
                    if (sticky_reg == abrg_pkg::RC_OK) begin
                        sticky_next = abrg_pkg::RC_STOPPED;
                    end
                    rc = (sticky_reg == abrg_pkg::RC_OK) ? abrg_pkg::RC_STOPPED : sticky_reg;
                    m_item_next.gap_first_sequence = gap_first_reg;
                    m_item_next.gap_timestamp      = gap_time_reg;
                    m_item_next.gap_count          = gap_count_reg;
                end
                default: begin
                    rc = abrg_pkg::RC_INVALID;
                end
            endcase
            m_item_next.result_code  = rc;
            m_item_next.queue_status = sticky_next;
            m_valid_next = 1'b1;
            state_next   = abrg_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= abrg_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            plane_count_reg <= abrg_pkg::PLANES_RST;
            bppf_reg        <= abrg_pkg::BPPF_RST;
            slot_count_reg  <= abrg_pkg::SLOTS_RST;
            write_slot_reg  <= '0;
            read_slot_reg   <= '0;
            filled_reg      <= '0;
            next_seq_reg    <= '0;
            gap_first_reg   <= '0;
            gap_time_reg    <= '0;
            gap_count_reg   <= '0;
            sticky_reg      <= abrg_pkg::RC_OK;
            fill_pos_reg    <= '0;
            fill_len_reg    <= '0;
            drain_pos_reg   <= '0;
            drain_len_reg   <= '0;
            filling_reg     <= 1'b0;
            draining_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            filled_reg     <= filled_next;
            next_seq_reg   <= next_seq_next;
            gap_first_reg  <= gap_first_next;
            gap_time_reg   <= gap_time_next;
            gap_count_reg  <= gap_count_next;
            sticky_reg     <= sticky_next;
            fill_pos_reg   <= fill_pos_next;
            fill_len_reg   <= fill_len_next;
            drain_pos_reg  <= drain_pos_next;
            drain_len_reg  <= drain_len_next;
            filling_reg    <= filling_next;
            draining_reg   <= draining_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    abrg_pkg::CFG_PLANES: plane_count_reg <= cfg_data[3:0];
                    abrg_pkg::CFG_BPPF:   bppf_reg        <= cfg_data;
                    abrg_pkg::CFG_SLOTS:  slot_count_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
        m_item_reg <= m_item_next;
    end

    abrg_store #(
        .SLOTS (MAX_SLOTS),
        .WORDS (WPS)
    ) u_store (
        .aclk        (aclk),
        .hdr_rd_en   (hdr_rd_en),
        .hdr_rd_addr (hdr_rd_addr),
        .hdr_rd_data (hdr_rd_data),
        .hdr_wr_en   (hdr_wr_en),
        .hdr_wr_addr (write_slot_reg),
        .hdr_wr_data (hdr_wr_data),
        .pay_rd_en   (pay_rd_en),
        .pay_rd_addr (pay_rd_addr),
        .pay_rd_data (pay_rd_data),
        .pay_wr_en   (pay_wr_en),
        .pay_wr_addr (pay_wr_addr),
        .pay_wr_data (item_reg.data_word)
    );

endmodule

FILE: hdl/abrg_checker.sv
// ----------------------------------------------------------------------------
// abrg_checker: port-level checks for the audio block ring
// Result handshake stability, sticky status and result field consistency.
// ----------------------------------------------------------------------------
module abrg_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input abrg_pkg::m_item_t m_item
);

    logic m_fire;
    logic sticky_seen_reg;

    assign m_fire = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_seen_reg <= 1'b0;
        end else if (m_fire && m_item.queue_status != abrg_pkg::RC_OK) begin
            sticky_seen_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && sticky_seen_reg |-> m_item.queue_status != abrg_pkg::RC_OK)
        else $error("sticky status cleared");

    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && (m_item.block_found || m_item.last_word)
        |-> m_item.result_code == abrg_pkg::RC_OK)
        else $error("block result without ok code");

    a_found_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && m_item.block_found |-> m_item.payload_word == 64'd0)
        else $error("pop header carried payload");

endmodule

bind audio_block_ring_with_gap_tracking abrg_checker u_abrg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
